>>> design/bmorph_pkg.sv
// Shared constants for the 3x3 binary morphology block.
package bmorph_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WCNT_W = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OP = 2'd2;

	localparam logic [7:0] PIX_BLACK = 8'h00;
	localparam logic [7:0] PIX_WHITE = 8'hff;

	localparam logic OP_DILATE = 1'b0;
	localparam logic OP_ERODE = 1'b1;

	localparam logic [11:0] RST_WIDTH = 12'd640;
	localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd480;

endpackage

>>> design/binary_morphology_3x3.sv
// 3x3 binary dilation and erosion of a raster pixel stream, black foreground.
//
// Pixels enter on the input channel (in_valid/in_ready) in raster order, one
// transaction per pixel, and the source follows each frame with image_width + 1
// pad transactions. The result for source pixel k is produced by the
// transaction that carries input item k + image_width + 1 and is presented on
// the output channel (out_valid/out_ready) in the following cycle. One pixel is
// accepted per clock unless a stall or a configuration transaction holds it off;
// window update and neighborhood test are combinational between the line store
// read register and the output register. The two line stores share one
// 2048 x 16 memory, read at the next column per accepted pixel so that its
// registered data is ready when the next pixel arrives. While the receiver
// stalls, the output register holds its result and the input channel takes a
// new pixel only if that result leaves in the same cycle. Reset clears the
// window, all counters and out_valid and loads the default configuration; the
// line stores are not cleared. A configuration transaction to a defined register
// restarts the stream, and a frame restarts by itself after its last result.
module binary_morphology_3x3
	import bmorph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            pixel_in,
	input  logic                  is_pad,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            pixel_out,
	output logic                  frame_last,
	output logic                  bad_pixel
);

	logic [11:0]      image_width_q;
	logic [ROW_W-1:0] image_height_q;
	logic             morph_op_q;

	logic [7:0]        win_q [9];
	logic [COL_W-1:0]  in_column_q;
	logic [COL_W-1:0]  out_column_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [WCNT_W-1:0] warmup_q;

	logic [15:0] line_mem [MAX_WIDTH];
	logic [15:0] rd_data_q;

	logic        out_valid_q;
	logic [7:0]  pixel_out_q;
	logic        frame_last_q;
	logic        bad_pixel_q;

	logic              cfg_we;
	logic              cfg_restart;
	logic              accept;
	logic [WCNT_W-1:0] w_eff;
	logic [ROW_W:0]    h_eff;
	logic [7:0]        px;
	logic [7:0]        win_d [9];
	logic [COL_W-1:0]  col_next;
	logic              col_wrap;
	logic [COL_W-1:0]  rd_addr;
	logic [15:0]       wr_data;
	logic              produce;
	logic              row_first;
	logic              row_end;
	logic              col_first;
	logic              col_end;
	logic              last;
	logic              hit;
	logic [7:0]        hit_val;
	logic [7:0]        result;
	logic              centre_bad;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid;
	assign cfg_restart = cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_OP});
	assign in_ready = (!out_valid_q || out_ready) && !cfg_valid;
	assign accept = in_valid && in_ready;

	always_comb begin
		if (image_width_q == 12'd0) begin
			w_eff = WCNT_W'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? (ROW_W+1)'(1) : {1'b0, image_height_q};
	end

	assign px = is_pad ? PIX_BLACK : pixel_in;
	assign wr_data = {rd_data_q[7:0], px};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r*3+0] = win_q[r*3+1];
			win_d[r*3+1] = win_q[r*3+2];
		end
		win_d[2] = rd_data_q[15:8];
		win_d[5] = rd_data_q[7:0];
		win_d[8] = px;
	end

	assign col_wrap = (WCNT_W'(in_column_q) + WCNT_W'(1)) >= w_eff;
	assign col_next = col_wrap ? '0 : in_column_q + COL_W'(1);

	assign produce = warmup_q >= (w_eff + WCNT_W'(1));
	assign row_first = out_row_q == '0;
	assign row_end = ({1'b0, out_row_q} + (ROW_W+1)'(1)) >= h_eff;
	assign col_first = out_column_q == '0;
	assign col_end = (WCNT_W'(out_column_q) + WCNT_W'(1)) >= w_eff;
	assign last = row_end && col_end;

	always_comb begin
		hit_val = (morph_op_q == OP_ERODE) ? PIX_WHITE : PIX_BLACK;
		hit = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!((r == 0) && row_first) && !((r == 2) && row_end) &&
				    !((c == 0) && col_first) && !((c == 2) && col_end) &&
				    (win_d[r*3+c] == hit_val)) begin
					hit = 1'b1;
				end
			end
		end
		if (morph_op_q == OP_ERODE) begin
			result = hit ? PIX_WHITE : PIX_BLACK;
		end else begin
			result = hit ? PIX_BLACK : PIX_WHITE;
		end
		centre_bad = (win_d[4] != PIX_BLACK) && (win_d[4] != PIX_WHITE);
	end

	always_comb begin
		if (cfg_restart) begin
			rd_addr = '0;
		end else if (accept) begin
			rd_addr = (produce && last) ? '0 : col_next;
		end else begin
			rd_addr = in_column_q;
		end
	end

	// Line memory: the write and the read of the same cycle may hit one entry
	// when the row is a single pixel wide, so the written word is forwarded.
	always_ff @(posedge clk) begin
		if (accept && !cfg_we) begin
			line_mem[in_column_q] <= wr_data;
		end
		if (accept && !cfg_we && (rd_addr == in_column_q)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
			morph_op_q <= OP_DILATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  image_width_q <= cfg_data[11:0];
				REG_HEIGHT: image_height_q <= cfg_data[ROW_W-1:0];
				REG_OP:     morph_op_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			in_column_q <= '0;
			out_column_q <= '0;
			out_row_q <= '0;
			warmup_q <= '0;
		end else if (cfg_restart) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			in_column_q <= '0;
			out_column_q <= '0;
			out_row_q <= '0;
			warmup_q <= '0;
		end else if (accept && !cfg_we) begin
			if (produce && last) begin
				for (int i = 0; i < 9; i++) begin
					win_q[i] <= '0;
				end
				in_column_q <= '0;
				out_column_q <= '0;
				out_row_q <= '0;
				warmup_q <= '0;
			end else begin
				for (int i = 0; i < 9; i++) begin
					win_q[i] <= win_d[i];
				end
				in_column_q <= col_next;
				if (produce) begin
					if (col_end) begin
						out_column_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_column_q <= out_column_q + COL_W'(1);
					end
				end else begin
					warmup_q <= warmup_q + WCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !cfg_we && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_we && produce) begin
			pixel_out_q <= result;
			frame_last_q <= last;
			bad_pixel_q <= centre_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_last = frame_last_q;
	assign bad_pixel = bad_pixel_q;

endmodule
